// ===== hdl/ptra_pkg.sv =====
// Shared types, constants and tables for the point transform range block.
`timescale 1ns / 1ps
package ptra_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam int CORDIC_STEPS = 16;
  localparam int IW = $clog2(CORDIC_STEPS);
  localparam int WW = 51;   // working coordinate width during rotation
  localparam int ZW = 36;   // angle accumulator width, Q30
  localparam int FW = 30;   // multiplier factor width
  localparam int CHUNK = 13;
  localparam int NCHUNK = 4;
  localparam int MW = CHUNK * NCHUNK;
  localparam int PW = CHUNK + FW;
  localparam int ACCW = MW + FW;
  localparam int KW = $clog2(NCHUNK);

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [FW-1:0] KINV_Q30 = 30'd652032874;
  localparam logic signed [ZW-1:0] PI_Q30     = 36'sd3373259426;
  localparam logic signed [ZW-1:0] TWOPI_Q30  = 36'sd6746518852;
  localparam logic signed [ZW-1:0] HALFPI_Q30 = 36'sd1686629713;

  typedef struct packed {
    logic [1:0]         mode;
    logic               op_kind;
    logic [18:0]        op_value;
    logic [10:0]        range_first;
    logic [10:0]        range_last;
    logic signed [47:0] point_x;
    logic signed [47:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] result_x;
    logic signed [47:0] result_y;
    logic               range_error;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic load_query;
    logic append;
    logic clear;
    logic fetch;
    logic decode;
    logic reduce;
    logic quad;
    logic cordic_step;
    logic mul_load;
    logic mul_step;
    logic round;
    logic sel_y;
    logic next_idx;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic range_bad;
    logic is_rot;
    logic last_entry;
    logic cordic_done;
    logic mul_done;
    logic out_free;
  } sts_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [IW-1:0] i);
    logic signed [ZW-1:0] a;
    a = '0;
    unique case (i)
      4'd0:  a = 36'sd843314857;
      4'd1:  a = 36'sd497837829;
      4'd2:  a = 36'sd263043837;
      4'd3:  a = 36'sd133525159;
      4'd4:  a = 36'sd67021687;
      4'd5:  a = 36'sd33543516;
      4'd6:  a = 36'sd16775851;
      4'd7:  a = 36'sd8388437;
      4'd8:  a = 36'sd4194283;
      4'd9:  a = 36'sd2097149;
      4'd10: a = 36'sd1048576;
      4'd11: a = 36'sd524288;
      4'd12: a = 36'sd262144;
      4'd13: a = 36'sd131072;
      4'd14: a = 36'sd65536;
      4'd15: a = 36'sd32768;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/point_transform_range_apply_top.sv =====
// Top level of the point transform range block: controller plus datapath.
`timescale 1ns / 1ps
// Channel  | Direction | Ports                         | Transfer when
// input    | in        | in_valid, in_stall, in_data   | in_valid && !in_stall
// result   | out       | out_valid, out_stall, out_data| out_valid && !out_stall
//
// Append and clear finish as they are accepted. A query is accepted, then for
// each entry runs fetch, decode, for a rotation reduce, quadrant and 16 CORDIC
// iterations on one shared adder set, and two 4-step serial multiplies for scale
// or gain, then loads the result; a bad range goes straight to the result load.
// Reset is synchronous, active low, and clears the entry count and state.
// A result held under out_stall blocks only the load of the next query's result.
module point_transform_range_apply_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ptra_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ptra_pkg::out_item_t out_data
);
  import ptra_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic idle;

  // Accept a transfer only when the sequencer is idle.
  assign in_stall = !idle;

  ptra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle)
  );

  ptra_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Never overwrite a result that is still held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  // A loaded result shows on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  // A range error never reports overflow.
  a_err_no_ov: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.range_error && out_data.overflow))
    else $error("range error with overflow");

endmodule

// ===== hdl/ptra_ctrl.sv =====
// Sequencing state machine for the point transform range block.
`timescale 1ns / 1ps
module ptra_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_mode,
  input  ptra_pkg::sts_t sts,
  output ptra_pkg::cmd_t cmd,
  output logic          idle
);
  import ptra_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_FETCH  = 13'b0000000000010,
    S_DECODE = 13'b0000000000100,
    S_RED    = 13'b0000000001000,
    S_QUAD   = 13'b0000000010000,
    S_CORD   = 13'b0000000100000,
    S_MLDX   = 13'b0000001000000,
    S_MULX   = 13'b0000010000000,
    S_RNDX   = 13'b0000100000000,
    S_MLDY   = 13'b0001000000000,
    S_MULY   = 13'b0010000000000,
    S_RNDY   = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_mode)
            MODE_APPEND: cmd.append = 1'b1;
            MODE_CLEAR:  cmd.clear = 1'b1;
            MODE_QUERY: begin
              cmd.load_query = 1'b1;
              state_nxt = sts.range_bad ? S_DONE : S_FETCH;
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt = sts.is_rot ? S_RED : S_MLDX;
      end
      S_RED: begin
        cmd.reduce = 1'b1;
        state_nxt = S_QUAD;
      end
      S_QUAD: begin
        cmd.quad = 1'b1;
        state_nxt = S_CORD;
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        if (sts.cordic_done) state_nxt = S_MLDX;
      end
      S_MLDX: begin
        cmd.mul_load = 1'b1;
        state_nxt = S_MULX;
      end
      S_MULX: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_done) state_nxt = S_RNDX;
      end
      S_RNDX: begin
        cmd.round = 1'b1;
        state_nxt = S_MLDY;
      end
      S_MLDY: begin
        cmd.mul_load = 1'b1;
        cmd.sel_y = 1'b1;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_done) state_nxt = S_RNDY;
      end
      S_RNDY: begin
        cmd.round = 1'b1;
        cmd.sel_y = 1'b1;
        cmd.next_idx = 1'b1;
        state_nxt = sts.last_entry ? S_DONE : S_FETCH;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/ptra_dp.sv =====
// Datapath: operation table, CORDIC rotator, serial multiplier and result register.
`timescale 1ns / 1ps
module ptra_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  ptra_pkg::in_item_t in_data,
  input  ptra_pkg::cmd_t     cmd,
  output ptra_pkg::sts_t     sts,
  input  logic               out_stall,
  output logic               out_valid,
  output ptra_pkg::out_item_t out_data
);
  import ptra_pkg::*;

  logic [19:0]            mem [TABLE_DEPTH];
  logic [CW-1:0]          op_count_r;
  logic [19:0]            rd_r;
  logic [CW-1:0]          idx_r;
  logic [10:0]            last_r;
  logic signed [47:0]     x_r, y_r;
  logic signed [WW-1:0]   wx_r, wy_r;
  logic signed [ZW-1:0]   z_r;
  logic [IW-1:0]          it_r;
  logic [MW-1:0]          m_r;
  logic                   neg_r;
  logic [FW-1:0]          f_r;
  logic                   sh30_r;
  logic [KW-1:0]          k_r;
  logic [ACCW-1:0]        acc_r;
  logic                   ov_r, err_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic signed [ZW-1:0]   z0;
  logic signed [WW-1:0]   mv, dx, dy;
  logic [PW-1:0]          prod;
  logic [ACCW-1:0]        rnd;
  logic [47:0]            sat;
  logic                   sat_ov;

  assign sts.range_bad = (in_data.range_first == 11'd0) ||
                         (in_data.range_first > in_data.range_last) ||
                         (32'(in_data.range_last) > 32'(op_count_r));
  assign sts.is_rot      = rd_r[19];
  assign sts.last_entry  = (32'(idx_r) + 32'd1 == 32'(last_r));
  assign sts.cordic_done = (it_r == IW'(CORDIC_STEPS - 1));
  assign sts.mul_done    = (k_r == KW'(NCHUNK - 1));
  assign sts.out_free    = !out_valid_r || !out_stall;

  assign z0   = ZW'({rd_r[18:0], 14'd0});
  assign mv   = cmd.sel_y ? wy_r : wx_r;
  assign dx   = wy_r >>> it_r;
  assign dy   = wx_r >>> it_r;
  assign prod = PW'(m_r[MW-1 -: CHUNK]) * PW'(f_r);

  // Round the magnitude half up (half away from zero) at the selected fraction point, then clamp to 48 bits.
  always_comb begin
    rnd = sh30_r ? ((acc_r + (ACCW'(1) << 29)) >> 30)
                 : ((acc_r + (ACCW'(1) << 15)) >> 16);
    sat_ov = 1'b0;
    if (neg_r) begin
      if (rnd >= (ACCW'(1) << 47)) begin
        sat = 48'h800000000000;
        sat_ov = (rnd > (ACCW'(1) << 47));
      end else begin
        sat = 48'(-rnd[47:0]);
      end
    end else begin
      if (rnd > ((ACCW'(1) << 47) - ACCW'(1))) begin
        sat = 48'h7FFFFFFFFFFF;
        sat_ov = 1'b1;
      end else begin
        sat = rnd[47:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && (32'(op_count_r) < TABLE_DEPTH)) begin
      mem[op_count_r[AW-1:0]] <= {in_data.op_kind, in_data.op_value};
    end
    if (cmd.fetch) begin
      rd_r <= mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_count_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        op_count_r <= '0;
      end else if (cmd.append && (32'(op_count_r) < TABLE_DEPTH)) begin
        op_count_r <= op_count_r + CW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      x_r    <= in_data.point_x;
      y_r    <= in_data.point_y;
      idx_r  <= CW'(in_data.range_first) - CW'(1);
      last_r <= in_data.range_last;
      ov_r   <= 1'b0;
      err_r  <= sts.range_bad;
    end
    if (cmd.decode) begin
      wx_r   <= WW'(x_r);
      wy_r   <= WW'(y_r);
      f_r    <= rd_r[19] ? KINV_Q30 : FW'(rd_r[18:0]);
      sh30_r <= rd_r[19];
      z_r    <= (z0 >= TWOPI_Q30) ? z0 - TWOPI_Q30 : z0;
      it_r   <= '0;
    end
    if (cmd.reduce && (z_r > PI_Q30)) begin
      z_r <= z_r - TWOPI_Q30;
    end
    // Exact quarter turn brings the angle into CORDIC range.
    if (cmd.quad) begin
      if (z_r > HALFPI_Q30) begin
        wx_r <= -wy_r;
        wy_r <= wx_r;
        z_r  <= z_r - HALFPI_Q30;
      end else if (z_r < -HALFPI_Q30) begin
        wx_r <= wy_r;
        wy_r <= -wx_r;
        z_r  <= z_r + HALFPI_Q30;
      end
    end
    if (cmd.cordic_step) begin
      if (z_r >= 0) begin
        wx_r <= wx_r - dx;
        wy_r <= wy_r + dy;
        z_r  <= z_r - atan_q30(it_r);
      end else begin
        wx_r <= wx_r + dx;
        wy_r <= wy_r - dy;
        z_r  <= z_r + atan_q30(it_r);
      end
      it_r <= it_r + IW'(1);
    end
    if (cmd.mul_load) begin
      neg_r <= mv[WW-1];
      m_r   <= MW'(mv[WW-1] ? -mv : mv);
      acc_r <= '0;
      k_r   <= '0;
    end
    // Most significant chunk first: shift the partial sum up and add.
    if (cmd.mul_step) begin
      acc_r <= (acc_r << CHUNK) + ACCW'(prod);
      m_r   <= m_r << CHUNK;
      k_r   <= k_r + KW'(1);
    end
    if (cmd.round) begin
      if (cmd.sel_y) y_r <= sat;
      else x_r <= sat;
      if (sat_ov) ov_r <= 1'b1;
    end
    if (cmd.next_idx) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.out_load) begin
      out_r.result_x    <= x_r;
      out_r.result_y    <= y_r;
      out_r.range_error <= err_r;
      out_r.overflow    <= ov_r && !err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
